// ===== hw/rtl/rsst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsst_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int unsigned POS_W      = 10;
  localparam int unsigned RANGE_W    = 11;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned LEAVES_DEF = 1024;

  // Request kinds.
  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Sequencer states of the tree engine.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_SUM,
    ST_DONE
  } rsst_state_e;

  // One request transaction as it travels from the top level to the engine.
  typedef struct packed {
    logic                req_type;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;
    logic [RANGE_W-1:0]  range_low;
    logic [RANGE_W-1:0]  range_high;
  } rsst_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsst_node_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsst_node_mem
  import rsst_pkg::*;
#(
  parameter int unsigned DEPTH  = 2 * LEAVES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_addr_a_i,
  input  wire logic [ADDR_W-1:0] rd_addr_b_i,
  output logic      [DATA_W-1:0] rd_data_a_o,
  output logic      [DATA_W-1:0] rd_data_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and two registered read ports; a read returns the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsst_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsst_engine
  import rsst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF,
  parameter int unsigned NODE_W = $clog2(2 * LEAVES),
  parameter int unsigned CNT_W  = $clog2(2 * LEAVES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request side.
  input  wire logic              req_valid_i,
  input  wire rsst_req_t         req_i,
  output logic                   req_stall_o,
  // Result side.
  output logic                   res_valid_o,
  output logic      [DATA_W-1:0] res_sum_o,
  input  wire logic              res_free_i,
  // Node memory.
  output logic                   wr_en_o,
  output logic      [NODE_W-1:0] wr_addr_o,
  output logic      [DATA_W-1:0] wr_data_o,
  output logic      [NODE_W-1:0] rd_addr_a_o,
  output logic      [NODE_W-1:0] rd_addr_b_o,
  input  wire logic [DATA_W-1:0] rd_data_a_i,
  input  wire logic [DATA_W-1:0] rd_data_b_i
);

  localparam int unsigned CMP_W  = (RANGE_W > CNT_W) ? RANGE_W : CNT_W;
  localparam int unsigned PCMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(2 * LEAVES - 1);

  rsst_state_e       state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic              take_a_q, take_a_d;
  logic              take_b_q, take_b_d;
  logic [DATA_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [DATA_W-1:0] left_q, left_d;
  logic [DATA_W-1:0] right_q, right_d;
  logic [DATA_W-1:0] sum_q, sum_d;

  logic              accept;
  logic              pos_ok;
  logic [NODE_W-1:0] leaf_node;
  logic [CNT_W-1:0]  lo_sat;
  logic [CNT_W-1:0]  hi_sat;
  logic [NODE_W-1:0] parent;
  logic [CNT_W-1:0]  hi_m1;

  assign accept = req_valid_i && (state_q == ST_IDLE);

  // Leaf address of an assign and the saturated bounds of a query.
  always_comb begin
    pos_ok    = PCMP_W'(req_i.position) < PCMP_W'(LEAVES);
    leaf_node = NODE_W'(LEAVES) + NODE_W'(req_i.position);
    lo_sat    = (CMP_W'(req_i.range_low) > CMP_W'(LEAVES)) ? CNT_W'(LEAVES)
                                                           : CNT_W'(req_i.range_low);
    hi_sat    = (CMP_W'(req_i.range_high) > CMP_W'(LEAVES)) ? CNT_W'(LEAVES)
                                                            : CNT_W'(req_i.range_high);
    parent    = node_q >> 1;
    hi_m1     = hi_q - CNT_W'(1);
  end

  // Sequencer: clearing pass, leaf-to-root update walk and two-sided query climb.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    take_a_d    = take_a_q;
    take_b_d    = take_b_q;
    cur_d       = cur_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    left_d      = left_q;
    right_d     = right_q;
    sum_d       = sum_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = clr_q;
    wr_data_o   = '0;
    rd_addr_a_o = lo_q[NODE_W-1:0];
    rd_addr_b_o = hi_m1[NODE_W-1:0];
    req_stall_o = (state_q != ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    res_sum_o   = sum_q;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en_o = 1'b1;
        clr_d   = clr_q + NODE_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        take_a_d = 1'b0;
        take_b_d = 1'b0;
        if (accept) begin
          if (req_i.req_type == REQ_ASSIGN) begin
            if (pos_ok) begin
              // Store the leaf and fetch its sibling for the first parent sum.
              wr_en_o     = 1'b1;
              wr_addr_o   = leaf_node;
              wr_data_o   = req_i.value;
              rd_addr_a_o = leaf_node ^ NODE_W'(1);
              cur_d       = req_i.value;
              node_d      = leaf_node;
              state_d     = ST_UPD;
            end
          end else if (lo_sat >= hi_sat) begin
            sum_d   = '0;
            state_d = ST_DONE;
          end else begin
            lo_d    = lo_sat + CNT_W'(LEAVES);
            hi_d    = hi_sat + CNT_W'(LEAVES);
            left_d  = '0;
            right_d = '0;
            state_d = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        // Parent sum from the carried child value and the fetched sibling;
        // the next sibling read goes out in the same cycle.
        wr_en_o     = 1'b1;
        wr_addr_o   = parent;
        wr_data_o   = cur_q + rd_data_a_i;
        cur_d       = cur_q + rd_data_a_i;
        node_d      = parent;
        rd_addr_a_o = parent ^ NODE_W'(1);
        if ((parent >> 1) == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        // Add the nodes fetched last cycle, then issue the next pair.
        if (take_a_q) begin
          left_d = left_q + rd_data_a_i;
        end
        if (take_b_q) begin
          right_d = right_q + rd_data_b_i;
        end
        if (lo_q < hi_q) begin
          take_a_d = lo_q[0];
          take_b_d = hi_q[0];
          lo_d     = (lo_q + CNT_W'(lo_q[0])) >> 1;
          hi_d     = hi_q >> 1;
        end else begin
          take_a_d = 1'b0;
          take_b_d = 1'b0;
          state_d  = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d   = left_q + right_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      take_a_q <= 1'b0;
      take_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      take_a_q <= take_a_d;
      take_b_q <= take_b_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    node_q  <= node_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    left_q  <= left_d;
    right_q <= right_d;
    sum_q   <= sum_d;
  end

  // The clearing pass ends only after the last node has been zeroed.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_CLEAR && state_q != ST_CLEAR) |-> $past(clr_q) == CLR_LAST)
    else $error("clearing pass left before the last node");

  // A query never writes the node memory.
  a_qry_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY || state_q == ST_SUM) |-> !wr_en_o)
    else $error("node memory written during a query");

  // Each update step climbs exactly one level.
  a_upd_climb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && $past(state_q) == ST_UPD) |-> node_q == ($past(node_q) >> 1))
    else $error("update walk skipped a level");

  // A waiting result holds its sum and blocks new requests.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_free_i) |=> (state_q == ST_DONE && $stable(sum_q)
                                             && req_stall_o))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

// ===== hw/rtl/range_sum_segment_tree_top.sv =====
// Range-sum segment tree over LEAVES signed 64-bit positions.
// Request channel: in_valid_i / in_stall_o with req_type_i, position_i, value_i,
// range_low_i and range_high_i; a transaction is taken when valid is high and
// stall is low. An assign (req_type 0) stores value_i at position_i and refreshes
// every ancestor sum; positions at or beyond LEAVES are ignored. A query
// (req_type 1) returns the wrapping sum over [range_low_i, range_high_i), with
// both bounds saturated to LEAVES; an empty range returns zero.
// Result channel: out_valid_o / out_stall_i with range_sum_o, one transaction
// per query and none per assign.
// Timing: an assign walks from the leaf to the root, one tree level per cycle
// through the single write port of the node memory. A query climbs the tree
// one level per cycle to its result register, with both range ends read on the
// two memory read ports. One request is worked on at a time.
// Reset: a clearing pass zeroes all 2 * LEAVES nodes, one per cycle, while
// in_stall_o stays high.
// A stalled result holds in the output register; the engine may finish the next
// query behind it and then waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module range_sum_segment_tree_top
  import rsst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      req_type_i,
  input  wire logic        [POS_W-1:0]   position_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  input  wire logic        [RANGE_W-1:0] range_low_i,
  input  wire logic        [RANGE_W-1:0] range_high_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed      [DATA_W-1:0]  range_sum_o
);

  localparam int unsigned NODE_W = $clog2(2 * LEAVES);
  localparam int unsigned CNT_W  = $clog2(2 * LEAVES + 1);

  rsst_req_t         req;
  logic              res_valid;
  logic [DATA_W-1:0] res_sum;
  logic              res_free;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [NODE_W-1:0] rd_addr_a;
  logic [NODE_W-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_data_a;
  logic [DATA_W-1:0] rd_data_b;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_sum_q, out_sum_d;

  // Gather the request fields into one transaction.
  always_comb begin
    req.req_type   = req_type_i;
    req.position   = position_i;
    req.value      = $unsigned(value_i);
    req.range_low  = range_low_i;
    req.range_high = range_high_i;
  end

  rsst_engine #(
    .LEAVES (LEAVES),
    .NODE_W (NODE_W),
    .CNT_W  (CNT_W)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .req_stall_o (in_stall_o),
    .res_valid_o (res_valid),
    .res_sum_o   (res_sum),
    .res_free_i  (res_free),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b)
  );

  rsst_node_mem #(
    .DEPTH  (2 * LEAVES),
    .ADDR_W (NODE_W)
  ) u_node_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // Output register: loads a finished sum whenever it is empty or being drained.
  always_comb begin
    res_free    = !out_valid_q || !out_stall_i;
    out_valid_d = out_valid_q && out_stall_i;
    out_sum_d   = out_sum_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
      out_sum_d   = res_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q <= out_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = $signed(out_sum_q);

endmodule

`default_nettype wire

// ===== tb/tb_range_sum_segment_tree_top.sv =====
`timescale 1ns / 1ps

module tb_range_sum_segment_tree_top;
  import rsst_pkg::*;

  localparam int unsigned LEAVES       = LEAVES_DEF;
  localparam int unsigned NODE_W       = $clog2(2 * LEAVES);
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned NUM_DIR      = 25;
  localparam int unsigned NUM_CHUNKS   = 12;
  localparam int unsigned CHUNK_ITEMS  = 95;
  localparam logic [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

  // One directed transaction; fixed_sum is used only where has_fixed is set.
  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    logic               has_fixed;
    logic [DATA_W-1:0]  fixed_sum;
  } dir_row_t;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd1024, 1'b1, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd2047, 1'b1, 64'd0},
    '{REQ_ASSIGN, 10'd0,    S64_MAX,  11'd0,    11'd0,    1'b0, 64'd0},
    '{REQ_ASSIGN, 10'd1023, 64'd1,    11'd0,    11'd0,    1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd1024, 1'b1, S64_MIN},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1023, 11'd1024, 1'b1, 64'd1},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd1,    1'b1, S64_MAX},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd5,    11'd5,    1'b1, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1024, 11'd1024, 1'b1, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1000, 11'd10,   1'b1, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd2047, 11'd0,    1'b1, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1024, 11'd2047, 1'b1, 64'd0},
    '{REQ_ASSIGN, 10'd512,  S64_MIN,  11'd0,    11'd0,    1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd512,  11'd513,  1'b1, S64_MIN},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd1024, 1'b1, 64'd0},
    '{REQ_ASSIGN, 10'd1023, ALL_ONE,  11'd0,    11'd0,    1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1,    11'd1024, 1'b0, 64'd0},
    '{REQ_ASSIGN, 10'd0,    64'd0,    11'd0,    11'd0,    1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd2047, 1'b0, 64'd0},
    '{REQ_ASSIGN, 10'd1,    64'h5555_5555_5555_5555, 11'd0, 11'd0, 1'b0, 64'd0},
    '{REQ_ASSIGN, 10'd2,    64'hAAAA_AAAA_AAAA_AAAA, 11'd0, 11'd0, 1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd1,    11'd3,    1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd0,    11'd1023, 1'b0, 64'd0},
    '{REQ_ASSIGN, 10'd341,  64'h0123_4567_89AB_CDEF, 11'd0, 11'd0, 1'b0, 64'd0},
    '{REQ_QUERY,  10'd0,    64'd0,    11'd341,  11'd682,  1'b0, 64'd0}
  };

  // Clock, reset and every block input start at known values.
  logic                clk_i      = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                req_type   = REQ_ASSIGN;
  logic [POS_W-1:0]    position   = '0;
  logic [DATA_W-1:0]   value      = '0;
  logic [RANGE_W-1:0]  range_low  = '0;
  logic [RANGE_W-1:0]  range_high = '0;
  logic                out_stall  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [DATA_W-1:0]   range_sum_o;

  bit                  idling_on = 1'b0;
  int unsigned         stall_left = 0;
  int unsigned         cycles = 0;
  int unsigned         errors = 0;

  // Shadow copy of the node store and the range sums still owed by the block.
  logic [DATA_W-1:0]   node_sum [2*LEAVES];
  logic [DATA_W-1:0]   sums_due [$];

  always #1 clk_i = ~clk_i;

  range_sum_segment_tree_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type),
    .position_i   (position),
    .value_i      (value),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .range_sum_o  (range_sum_o)
  );

  // Stores a leaf and refreshes every ancestor sum up to the root.
  function automatic void store_leaf(int unsigned pos, logic [DATA_W-1:0] val);
    int unsigned k;
    if (pos >= LEAVES) return;
    k = pos + LEAVES;
    node_sum[NODE_W'(k)] = val;
    k = k >> 1;
    while (k != 0) begin
      node_sum[NODE_W'(k)] = node_sum[NODE_W'(2*k)] + node_sum[NODE_W'(2*k+1)];
      k = k >> 1;
    end
  endfunction

  // Wrapping sum over [lo, hi), both bounds clamped to the leaf count.
  function automatic logic [DATA_W-1:0] range_total(int unsigned lo, int unsigned hi);
    logic [DATA_W-1:0] left_acc;
    logic [DATA_W-1:0] right_acc;
    left_acc  = '0;
    right_acc = '0;
    if (lo > LEAVES) lo = LEAVES;
    if (hi > LEAVES) hi = LEAVES;
    if (lo >= hi) return '0;
    lo += LEAVES;
    hi += LEAVES;
    while (lo < hi) begin
      if (lo[0]) begin
        left_acc += node_sum[NODE_W'(lo)];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        right_acc += node_sum[NODE_W'(hi)];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return left_acc + right_acc;
  endfunction

  // Presents one request transaction, holds it until taken, then updates the
  // shadow tree or records the sum the block owes.
  task automatic send_request(input logic kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val,
                              input logic [RANGE_W-1:0] lo,
                              input logic [RANGE_W-1:0] hi,
                              input logic has_fixed,
                              input logic [DATA_W-1:0] fixed_sum);
    in_valid   <= 1'b1;
    req_type   <= kind;
    position   <= pos;
    value      <= val;
    range_low  <= lo;
    range_high <= hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == REQ_ASSIGN) begin
      store_leaf(32'(pos), val);
    end else begin
      sums_due.push_back(has_fixed ? fixed_sum : range_total(32'(lo), 32'(hi)));
    end
    // Random idle burst on the request side.
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Builds one random transaction. In local mode writes and queries crowd a
  // narrow window so that queries see many written leaves.
  task automatic send_random(input bit local_mode, input int unsigned base);
    logic               kind;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    logic [RANGE_W-1:0] tmp;
    int unsigned        pick;
    kind = ($urandom_range(0, 1) != 0) ? REQ_QUERY : REQ_ASSIGN;
    pos  = local_mode ? POS_W'(base + $urandom_range(0, 31))
                      : POS_W'($urandom_range(0, LEAVES - 1));
    case ($urandom_range(0, 15))
      0: val = S64_MAX;
      1: val = S64_MIN;
      2: val = ALL_ONE;
      3: val = '0;
      4, 5, 6, 7: val = 64'($urandom_range(0, 2000)) - 64'd1000;
      default: val = {$urandom, $urandom};
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      lo = RANGE_W'($urandom_range(0, 2047));
      hi = RANGE_W'($urandom_range(0, 2047));
    end else if (local_mode) begin
      lo = RANGE_W'(base + $urandom_range(0, 40));
      hi = RANGE_W'(base + $urandom_range(0, 40));
    end else begin
      lo = RANGE_W'($urandom_range(0, LEAVES));
      hi = RANGE_W'($urandom_range(0, LEAVES));
    end
    // Most ranges are put in order; the rest may come out reversed or empty.
    if (pick > 1 && lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    send_request(kind, pos, val, lo, hi, 1'b0, '0);
  endtask

  // Result side stalls in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each result transaction is checked against the oldest owed sum.
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (sums_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected range_sum, expected none, actual %0d", $time,
                 $signed(range_sum_o));
      end else begin
        want = sums_due.pop_front();
        if (range_sum_o !== want) begin
          errors++;
          $display("%0t: range_sum mismatch, expected %0d, actual %0d", $time,
                   $signed(want), $signed(range_sum_o));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, directed rows, random chunks, then drain.
  initial begin
    bit          local_mode;
    int unsigned base;
    foreach (node_sum[i]) node_sum[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_n     <= 1'b1;
    idling_on = 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].lo,
                   dir_rows[i].hi, dir_rows[i].has_fixed, dir_rows[i].fixed_sum);
    end

    // Chunks switch between local and spread access; the last two run without
    // any idling on either side.
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      local_mode = ($urandom_range(0, 1) != 0);
      base       = $urandom_range(0, LEAVES - 32);
      idling_on  = (c < NUM_CHUNKS - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) send_random(local_mode, base);
    end

    idling_on = 1'b0;
    in_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
